[sv/mfa_pkg.sv]
// Shared constants for the modular field arithmetic unit: field widths,
// operation codes and register reset values. No dependencies.
`timescale 1ns / 1ps

package mfa_pkg;

	// Fixed widths of the request and result fields at the ports.
	localparam int FIELD_W = 16;
	localparam int MODE_W  = 3;

	// Default width of the internal arithmetic.
	localparam int VALUE_WIDTH_DEFAULT = 16;

	// Modulus after reset: the largest prime below two to the sixteenth.
	localparam logic [FIELD_W-1:0] MODULUS_RESET = 16'd65521;

	// Operation codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INV = 3'd4;

endpackage

[sv/mfa_mulmod.sv]
// Bit-serial modular multiplier: interleaved double-and-add, a doubling
// and an add step per bit of the multiplier. Depends on no other file.
`timescale 1ns / 1ps

module mfa_mulmod #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] x,
	input  logic [VALUE_WIDTH-1:0] y,
	input  logic [VALUE_WIDTH-1:0] m,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] product
);

	localparam int W     = VALUE_WIDTH;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             phase_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     acc_q;
	logic [W-1:0]     ysh_q;

	logic [W:0] m_ext;
	logic [W:0] dbl;
	logic [W:0] sum;
	logic [W-1:0] dbl_red;
	logic [W-1:0] sum_red;

	// Doubling and addition, each followed by one conditional subtraction.
	always_comb begin
		m_ext   = {1'b0, m};
		dbl     = {acc_q, 1'b0};
		sum     = {1'b0, acc_q} + {1'b0, x};
		dbl_red = (dbl >= m_ext) ? W'(dbl - m_ext) : dbl[W-1:0];
		sum_red = (sum >= m_ext) ? W'(sum - m_ext) : sum[W-1:0];
	end

	// Sequencing of the bit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(W - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (cnt_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
		end
	end

	// Accumulator and multiplier shift register, most significant bit first.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ysh_q <= y;
		end else if (busy_q) begin
			if (!phase_q) begin
				acc_q <= dbl_red;
			end else begin
				if (ysh_q[W-1]) begin
					acc_q <= sum_red;
				end
				ysh_q <= {ysh_q[W-2:0], 1'b0};
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[sv/mfa_inverse.sv]
// Modular inverse by the extended Euclidean algorithm, each quotient
// found by shift-and-subtract one bit per cycle. No package dependencies.
`timescale 1ns / 1ps

module mfa_inverse #(
	parameter int VALUE_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] m,
	input  logic [VALUE_WIDTH-1:0] n,
	output logic                   done,
	output logic                   fail,
	output logic [VALUE_WIDTH-1:0] value
);

	localparam int W     = VALUE_WIDTH;
	localparam int TW    = W + 2;
	localparam int CNT_W = $clog2(W);

	localparam logic [2:0] I_IDLE  = 3'd0;
	localparam logic [2:0] I_CHECK = 3'd1;
	localparam logic [2:0] I_ALIGN = 3'd2;
	localparam logic [2:0] I_SUB   = 3'd3;
	localparam logic [2:0] I_FINAL = 3'd4;

	logic [2:0]       state_q;
	logic             done_q;
	logic [CNT_W-1:0] k_q;

	// Remainders, aligned divisor and the matching Bezout coefficients.
	logic [W-1:0]          r0_q;
	logic [W-1:0]          r1_q;
	logic [W:0]            d_q;
	logic signed [TW-1:0]  t0_q;
	logic signed [TW-1:0]  t1_q;
	logic signed [TW-1:0]  dt_q;
	logic                  fail_q;
	logic [W-1:0]          value_q;

	logic [W:0]           d_dbl;
	logic                 fits_dbl;
	logic                 fits;
	logic [W-1:0]         r0_sub;
	logic signed [TW-1:0] t0_sub;
	logic signed [TW-1:0] m_t;
	logic signed [TW-1:0] t_pos;
	logic signed [TW-1:0] t_red;

	// One quotient bit: compare the aligned divisor, subtract if it fits.
	always_comb begin
		d_dbl    = {d_q[W-1:0], 1'b0};
		fits_dbl = (d_dbl <= {1'b0, r0_q});
		fits     = (d_q <= {1'b0, r0_q});
		r0_sub   = fits ? W'({1'b0, r0_q} - d_q) : r0_q;
		t0_sub   = fits ? (t0_q - dt_q) : t0_q;
		m_t      = $signed({2'b00, m});
		t_pos    = t0_q[TW-1] ? (t0_q + m_t) : t0_q;
		t_red    = (t_pos >= m_t) ? (t_pos - m_t) : t_pos;
	end

	// Control: check, align, subtract per Euclid step, then final fix-up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				I_IDLE: begin
					if (start) begin
						state_q <= I_CHECK;
					end
				end
				I_CHECK: begin
					k_q     <= '0;
					state_q <= (r1_q == '0) ? I_FINAL : I_ALIGN;
				end
				I_ALIGN: begin
					if (fits_dbl) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= I_SUB;
					end
				end
				I_SUB: begin
					if (k_q == '0) begin
						state_q <= I_CHECK;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				I_FINAL: begin
					done_q  <= 1'b1;
					state_q <= I_IDLE;
				end
				default: begin
					state_q <= I_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			I_IDLE: begin
				if (start) begin
					r0_q <= m;
					r1_q <= n;
					t0_q <= '0;
					t1_q <= TW'(1);
				end
			end
			I_CHECK: begin
				d_q  <= {1'b0, r1_q};
				dt_q <= t1_q;
			end
			I_ALIGN: begin
				if (fits_dbl) begin
					d_q  <= d_dbl;
					dt_q <= dt_q <<< 1;
				end
			end
			I_SUB: begin
				if (k_q == '0) begin
					// Quotient complete: the remainder becomes the new divisor.
					r0_q <= r1_q;
					r1_q <= r0_sub;
					t0_q <= t1_q;
					t1_q <= t0_sub;
				end else begin
					r0_q <= r0_sub;
					t0_q <= t0_sub;
					d_q  <= d_q >> 1;
					dt_q <= dt_q >>> 1;
				end
			end
			I_FINAL: begin
				if (r0_q != W'(1)) begin
					fail_q  <= 1'b1;
					value_q <= '0;
				end else begin
					fail_q  <= 1'b0;
					value_q <= t_red[W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign fail  = fail_q;
	assign value = value_q;

endmodule

[sv/modular_field_alu_top.sv]
// Top level of the modular field arithmetic unit. Uses mfa_pkg, and
// instantiates mfa_inverse and mfa_mulmod.
`timescale 1ns / 1ps

// One request at a time is worked on, with W = VALUE_WIDTH. Both operands are
// first reduced by a bit-serial restoring remainder. Add and subtract are then
// formed directly from the reduced operands. Multiply runs the serial
// double-and-add multiplier, a doubling and an add step per operand bit.
// Inverse runs the extended Euclid unit: per Euclid step a check, an
// alignment of the divisor and one shift-and-subtract per quotient bit;
// divide adds a multiply on top of that. The next request is taken as soon
// as the previous result sits in the output register, even if it has not
// yet been collected. The modulus register is written through cfg_we and
// cfg_wdata; only its low VALUE_WIDTH bits are used, and a modulus below two
// acts as one. Modes 5 to 7 return zero.
module modular_field_alu_top
	import mfa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FIELD_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [MODE_W-1:0]  mode,
	input  logic [FIELD_W-1:0] operand_a,
	input  logic [FIELD_W-1:0] operand_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FIELD_W-1:0] result,
	output logic               no_inverse,
	output logic               operands_equal,
	output logic               a_less_than_b
);

	localparam int W     = VALUE_WIDTH;
	localparam int CNT_W = $clog2(W);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_REDUCE   = 3'd1;
	localparam logic [2:0] S_EXEC     = 3'd2;
	localparam logic [2:0] S_INV_WAIT = 3'd3;
	localparam logic [2:0] S_MUL_WAIT = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [FIELD_W-1:0] modulus_q;
	logic               out_valid_q;

	logic [MODE_W-1:0]  mode_q;
	logic [W-1:0]       sa_q;
	logic [W-1:0]       sb_q;
	logic [W-1:0]       ra_q;
	logic [W-1:0]       rb_q;
	logic [W-1:0]       res_q;
	logic               fail_q;
	logic               eq_q;
	logic               lt_q;
	logic [FIELD_W-1:0] result_q;
	logic               no_inverse_q;
	logic               equal_q;
	logic               less_q;

	logic               accept;
	logic               out_load;
	logic [W-1:0]       m_eff;
	logic [W:0]         m_ext;
	logic [W:0]         rem_a;
	logic [W:0]         rem_b;
	logic [W-1:0]       red_a;
	logic [W-1:0]       red_b;
	logic [W:0]         add_sum;
	logic [W-1:0]       add_res;
	logic [W-1:0]       sub_res;
	logic [W-1:0]       a_in;
	logic [W-1:0]       b_in;
	logic [W+FIELD_W-1:0] a_wide;
	logic [W+FIELD_W-1:0] b_wide;
	logic [W+FIELD_W-1:0] m_wide;
	logic [W+FIELD_W-1:0] res_wide;

	logic         inv_start;
	logic         inv_done;
	logic         inv_fail;
	logic [W-1:0] inv_value;
	logic [W-1:0] inv_n;
	logic         mul_start;
	logic         mul_done;
	logic [W-1:0] mul_y;
	logic [W-1:0] mul_product;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Fit the port fields to the internal width, and form the working modulus.
	always_comb begin
		a_wide   = {{W{1'b0}}, operand_a};
		b_wide   = {{W{1'b0}}, operand_b};
		m_wide   = {{W{1'b0}}, modulus_q};
		a_in     = a_wide[W-1:0];
		b_in     = b_wide[W-1:0];
		m_eff    = (m_wide[W-1:1] == '0) ? W'(1) : m_wide[W-1:0];
		m_ext    = {1'b0, m_eff};
		res_wide = {{FIELD_W{1'b0}}, res_q};
	end

	// Serial remainder step for both operands, and the add and subtract.
	always_comb begin
		rem_a   = {ra_q, sa_q[W-1]};
		rem_b   = {rb_q, sb_q[W-1]};
		red_a   = (rem_a >= m_ext) ? W'(rem_a - m_ext) : rem_a[W-1:0];
		red_b   = (rem_b >= m_ext) ? W'(rem_b - m_ext) : rem_b[W-1:0];
		add_sum = {1'b0, ra_q} + {1'b0, rb_q};
		add_res = (add_sum >= m_ext) ? W'(add_sum - m_ext) : add_sum[W-1:0];
		sub_res = (ra_q >= rb_q) ? (ra_q - rb_q) : W'({1'b0, ra_q} + m_ext - {1'b0, rb_q});
	end

	// Starts of the shared units.
	always_comb begin
		inv_n     = (mode_q == MODE_INV) ? ra_q : rb_q;
		inv_start = (state_q == S_EXEC) && ((mode_q == MODE_DIV) || (mode_q == MODE_INV));
		mul_y     = (state_q == S_INV_WAIT) ? inv_value : rb_q;
		mul_start = ((state_q == S_EXEC) && (mode_q == MODE_MUL)) ||
			((state_q == S_INV_WAIT) && inv_done && (mode_q == MODE_DIV));
	end

	// Control sequencer, modulus register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			modulus_q   <= MODULUS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= CNT_W'(W - 1);
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (cnt_q == '0) begin
						state_q <= S_EXEC;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_EXEC: begin
					case (mode_q)
						MODE_MUL: state_q <= S_MUL_WAIT;
						MODE_DIV: state_q <= S_INV_WAIT;
						MODE_INV: state_q <= S_INV_WAIT;
						default:  state_q <= S_DONE;
					endcase
				end
				S_INV_WAIT: begin
					if (inv_done) begin
						state_q <= (mode_q == MODE_DIV) ? S_MUL_WAIT : S_DONE;
					end
				end
				S_MUL_WAIT: begin
					if (mul_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand shift registers, remainders and the pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			sa_q   <= a_in;
			sb_q   <= b_in;
			ra_q   <= '0;
			rb_q   <= '0;
		end
		case (state_q)
			S_REDUCE: begin
				ra_q <= red_a;
				rb_q <= red_b;
				sa_q <= {sa_q[W-2:0], 1'b0};
				sb_q <= {sb_q[W-2:0], 1'b0};
			end
			S_EXEC: begin
				eq_q   <= (ra_q == rb_q);
				lt_q   <= (ra_q < rb_q);
				fail_q <= 1'b0;
				case (mode_q)
					MODE_ADD: res_q <= add_res;
					MODE_SUB: res_q <= sub_res;
					default:  res_q <= '0;
				endcase
			end
			S_INV_WAIT: begin
				if (inv_done) begin
					fail_q <= inv_fail;
					res_q  <= inv_value;
				end
			end
			S_MUL_WAIT: begin
				if (mul_done) begin
					res_q <= mul_product;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			result_q     <= res_wide[FIELD_W-1:0];
			no_inverse_q <= fail_q;
			equal_q      <= eq_q;
			less_q       <= lt_q;
		end
	end

	// Extended Euclid inverse unit.
	mfa_inverse #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_inverse (
		.clk   (clk),
		.arst_n(arst_n),
		.start (inv_start),
		.m     (m_eff),
		.n     (inv_n),
		.done  (inv_done),
		.fail  (inv_fail),
		.value (inv_value)
	);

	// Serial modular multiplier.
	mfa_mulmod #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (ra_q),
		.y      (mul_y),
		.m      (m_eff),
		.done   (mul_done),
		.product(mul_product)
	);

	assign out_valid      = out_valid_q;
	assign result         = result_q;
	assign no_inverse     = no_inverse_q;
	assign operands_equal = equal_q;
	assign a_less_than_b  = less_q;

endmodule

[test/tb_modular_field_alu_top.sv]
// Self-checking testbench for modular_field_alu_top: directed and random requests over a
// range of moduli, each result checked against a predictor of the modular arithmetic.
// Depends on mfa_pkg and modular_field_alu_top only.
`timescale 1ns / 1ps

module tb_modular_field_alu_top;
	import mfa_pkg::*;

	// Codes outside the defined operations, expected to give zero.
	localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = MODE_INV + 3'd1;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = '1;

	localparam int PHASE_REQUESTS   = 160;
	localparam int MAX_IDLE         = 16;
	localparam int LONG_HOLD_AT     = 300;
	localparam int LONG_HOLD_CYCLES = 1200;
	localparam int TAIL_CYCLES      = 400;
	localparam int STALL_LIMIT      = 20000;
	localparam int REPORT_LIMIT     = 10;

	typedef enum logic [1:0] {
		STEP_REQUEST,
		STEP_MODULUS,
		STEP_DRAIN
	} step_kind_t;

	// One entry of the stimulus plan: a request, a modulus write or a pause.
	typedef struct packed {
		step_kind_t         kind;
		logic [MODE_W-1:0]  mode;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
	} plan_step_t;

	typedef struct packed {
		logic [FIELD_W-1:0] result;
		logic               no_inverse;
		logic               operands_equal;
		logic               a_less_than_b;
	} field_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [FIELD_W-1:0] cfg_wdata = MODULUS_RESET;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [MODE_W-1:0]  mode = MODE_ADD;
	logic [FIELD_W-1:0] operand_a = '0;
	logic [FIELD_W-1:0] operand_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [FIELD_W-1:0] result;
	logic               no_inverse;
	logic               operands_equal;
	logic               a_less_than_b;

	plan_step_t    request_plan_q[$];
	field_result_t field_results_q[$];

	logic [FIELD_W-1:0] field_modulus = MODULUS_RESET;
	int unsigned        tx_gap = 0;
	bit                 tx_calm = 1'b0;
	int unsigned        rx_stall = 0;
	bit                 rx_calm = 1'b0;
	int                 results_seen = 0;
	int                 fault_count = 0;
	int                 idle_cycles = 0;

	modular_field_alu_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result         (result),
		.no_inverse     (no_inverse),
		.operands_equal (operands_equal),
		.a_less_than_b  (a_less_than_b)
	);

	always #2 clk = ~clk;

	// Extended Euclid: inverse of n modulo m, zero when the two share a factor.
	function automatic longint unsigned field_inverse(input longint unsigned m,
			input longint unsigned n, output bit shares_factor);
		longint r0, r1, t0, t1, q, rn, tn;
		r0 = longint'(m);
		r1 = longint'(n);
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q  = r0 / r1;
			rn = r0 - q * r1;
			tn = t0 - q * t1;
			r0 = r1;
			r1 = rn;
			t0 = t1;
			t1 = tn;
		end
		shares_factor = (r0 != 1);
		if (shares_factor)
			return 0;
		if (t0 < 0)
			t0 = t0 + longint'(m);
		return longint'(t0 % longint'(m));
	endfunction

	// Expected outcome of one request under the given modulus.
	function automatic field_result_t predict_field_op(input logic [MODE_W-1:0] op,
			input logic [FIELD_W-1:0] opa, input logic [FIELD_W-1:0] opb,
			input logic [FIELD_W-1:0] modv);
		longint unsigned m, a, b, inv, res;
		bit              fail;
		field_result_t   r;
		m    = (modv < 2) ? 1 : modv;
		a    = opa % m;
		b    = opb % m;
		fail = 1'b0;
		case (op)
			MODE_ADD: res = (a + b) % m;
			MODE_SUB: res = (a + m - b) % m;
			MODE_MUL: res = (a * b) % m;
			MODE_DIV: begin
				inv = field_inverse(m, b, fail);
				res = (a * inv) % m;
			end
			MODE_INV: res = field_inverse(m, a, fail);
			default:  res = 0;
		endcase
		r.result         = res[FIELD_W-1:0];
		r.no_inverse     = fail;
		r.operands_equal = (a == b);
		r.a_less_than_b  = (a < b);
		return r;
	endfunction

	function automatic void plan_request(input logic [MODE_W-1:0] op,
			input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
		request_plan_q.push_back('{STEP_REQUEST, op, a, b});
	endfunction

	function automatic void plan_modulus(input logic [FIELD_W-1:0] value);
		request_plan_q.push_back('{STEP_MODULUS, MODE_ADD, value, '0});
	endfunction

	function automatic void plan_drain();
		request_plan_q.push_back('{STEP_DRAIN, MODE_ADD, '0, '0});
	endfunction

	// Operand mix: edges around the modulus, reduced values and raw 16-bit values.
	function automatic logic [FIELD_W-1:0] draw_operand(input logic [FIELD_W-1:0] modv);
		int unsigned m;
		m = (modv < 2) ? 1 : modv;
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return FIELD_W'(m - 1);
			3:       return FIELD_W'(m);
			4:       return FIELD_W'(m + 1);
			5, 6, 7: return FIELD_W'($urandom_range(0, m - 1));
			default: return FIELD_W'($urandom());
		endcase
	endfunction

	// Request driver: works through the plan, pausing for modulus writes and drains.
	always @(posedge clk or negedge arst_n) begin : request_driver
		logic       taken;
		logic       next_valid;
		plan_step_t head;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			cfg_we        <= 1'b0;
			tx_gap        = 0;
			field_modulus = MODULUS_RESET;
		end else begin
			taken      = in_valid && in_ready;
			next_valid = in_valid && !taken;
			if (taken) begin
				field_results_q.push_back(predict_field_op(mode, operand_a, operand_b,
						field_modulus));
				tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
				if ($urandom_range(0, 24) == 0)
					tx_calm = !tx_calm;
			end
			if (cfg_we)
				cfg_we <= 1'b0;
			if (!next_valid && !cfg_we) begin
				if (tx_gap != 0) begin
					tx_gap--;
				end else if (request_plan_q.size() != 0) begin
					head = request_plan_q[0];
					case (head.kind)
						STEP_REQUEST: begin
							head       = request_plan_q.pop_front();
							mode       <= head.mode;
							operand_a  <= head.a;
							operand_b  <= head.b;
							next_valid = 1'b1;
						end
						STEP_MODULUS: begin
							// The block must be idle before its modulus changes.
							if (field_results_q.size() == 0) begin
								head          = request_plan_q.pop_front();
								cfg_we        <= 1'b1;
								cfg_wdata     <= head.a;
								field_modulus = head.a;
							end
						end
						default: begin
							if (field_results_q.size() == 0)
								head = request_plan_q.pop_front();
						end
					endcase
				end
			end
			in_valid <= next_valid;
		end
	end

	// Result monitor: checks each result in order and throttles out_ready.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		field_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall  = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (field_results_q.size() == 0) begin
					if (fault_count < REPORT_LIMIT)
						$display("unexpected result %0d with no request outstanding", result);
					fault_count++;
				end else begin
					want = field_results_q.pop_front();
					if ({result, no_inverse, operands_equal, a_less_than_b} !== want) begin
						if (fault_count < REPORT_LIMIT)
							$display("mismatch on result %0d: ", results_seen,
									"expected %0d/%0b/%0b/%0b, ", want.result,
									want.no_inverse, want.operands_equal,
									want.a_less_than_b,
									"got %0d/%0b/%0b/%0b ", result, no_inverse,
									operands_equal, a_less_than_b,
									"(result/no_inverse/equal/less)");
						fault_count++;
					end
				end
				rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
				// One long hold-off so that the block backs up and stalls its input.
				if (results_seen == LONG_HOLD_AT)
					rx_stall = LONG_HOLD_CYCLES;
				if ($urandom_range(0, 24) == 0)
					rx_calm = !rx_calm;
			end
			if (rx_stall != 0) begin
				rx_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles in which nothing at all is accepted.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("tb_modular_field_alu_top NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Builds the plan, releases reset and waits for the run to drain.
	initial begin : run_control
		logic [FIELD_W-1:0] phase_moduli [12];
		logic [MODE_W-1:0]  op;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;

		// Directed requests under the reset modulus: extremes and wrap-around.
		plan_request(MODE_ADD, '1, '1);
		plan_request(MODE_ADD, 16'd65520, 16'd1);
		plan_request(MODE_ADD, '0, '0);
		plan_request(MODE_SUB, '0, '1);
		plan_request(MODE_SUB, 16'd5, 16'd5);
		plan_request(MODE_SUB, MODULUS_RESET, '0);
		plan_request(MODE_MUL, '1, '1);
		plan_request(MODE_MUL, 16'd65520, 16'd65520);
		// Division by zero, an ordinary division, and a divisor that reduces to zero.
		plan_request(MODE_DIV, 16'd7, '0);
		plan_request(MODE_DIV, 16'd12345, 16'd6789);
		plan_request(MODE_DIV, '1, MODULUS_RESET);
		// Inverse of zero, of one and of minus one.
		plan_request(MODE_INV, '0, 16'd1234);
		plan_request(MODE_INV, 16'd1, '0);
		plan_request(MODE_INV, 16'd65520, '1);
		// Unused codes still produce the compare flags.
		plan_request(MODE_UNUSED_FIRST, 16'd3, 16'd9);
		plan_request(MODE_UNUSED_FIRST + 3'd1, 16'd9, 16'd3);
		plan_request(MODE_UNUSED_LAST, '1, '0);
		// Composite modulus: values sharing a factor have no inverse.
		plan_modulus(16'd12);
		plan_request(MODE_INV, 16'd4, '0);
		plan_request(MODE_DIV, 16'd5, 16'd6);
		plan_request(MODE_INV, 16'd5, '0);
		plan_request(MODE_DIV, 16'd7, 16'd5);
		// Modulus one and zero collapse everything to zero.
		plan_modulus(16'd1);
		plan_request(MODE_INV, '0, '0);
		plan_request(MODE_DIV, 16'd3, 16'd2);
		plan_modulus('0);
		plan_request(MODE_MUL, '1, '1);

		// Random phases, one modulus each, with a drain in every other phase.
		phase_moduli = '{16'd65535, 16'd0, 16'd1, 16'd2, 16'd3, 16'd12, 16'd256,
				16'd65534, 16'd257, FIELD_W'($urandom_range(2, 65535)),
				FIELD_W'($urandom_range(2, 255)), MODULUS_RESET};
		for (int p = 0; p < 12; p++) begin
			plan_modulus(phase_moduli[p]);
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				if (p % 2 == 1 && i == PHASE_REQUESTS / 2)
					plan_drain();
				if ($urandom_range(0, 15) == 0)
					op = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
				else
					op = MODE_W'($urandom_range(MODE_ADD, MODE_INV));
				a = draw_operand(phase_moduli[p]);
				b = ($urandom_range(0, 7) == 0) ? a : draw_operand(phase_moduli[p]);
				plan_request(op, a, b);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_plan_q.size() != 0 || in_valid || cfg_we || field_results_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		fault_count += field_results_q.size();
		if (fault_count == 0)
			$display("tb_modular_field_alu_top OK");
		else
			$display("tb_modular_field_alu_top NOT OK");
		$finish;
	end

endmodule

[modular_field_alu_top.f]
sv/mfa_pkg.sv
sv/mfa_mulmod.sv
sv/mfa_inverse.sv
sv/modular_field_alu_top.sv
test/tb_modular_field_alu_top.sv
